// File: hdl/nsb_pkg.sv
// ----------------------------------------------------------------------------
// nsb_pkg
// Shared types and constants for the nibble sprite blitter.
// ----------------------------------------------------------------------------
package nsb_pkg;

   localparam int ADDR_W  = 15;
   localparam int COLOR_W = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
   localparam logic [7:0] HIGH_NIBBLE = 8'hF0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEST_X        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_Y        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_HEIGHT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TRANSPARENT   = 3'd6;

   typedef struct packed {
      logic signed [9:0] dest_x;
      logic signed [9:0] dest_y;
      logic [7:0]        sprite_width;
      logic [7:0]        sprite_height;
      logic [7:0]        clip_width;
      logic [7:0]        clip_height;
      logic [3:0]        transparent;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [COLOR_W-1:0] color;
      logic               upper;
   } pix_type;

   typedef struct packed {
      logic    en;
      pix_type pix;
   } wr_type;

endpackage

// File: hdl/nsb_csr.sv
// ----------------------------------------------------------------------------
// nsb_csr
// Configuration registers; any write to a used index also restarts the sprite cursor.
// ----------------------------------------------------------------------------
module nsb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nsb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nsb_pkg::CSR_DATA_W-1:0]    csr_data,
   output nsb_pkg::cfg_type                  cfg,
   output logic                              restart
);

   nsb_pkg::cfg_type cfg_ff, cfg_in;
   logic             hit;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b1;
      unique case (csr_index)
         nsb_pkg::REG_DEST_X:        cfg_in.dest_x        = csr_data;
         nsb_pkg::REG_DEST_Y:        cfg_in.dest_y        = csr_data;
         nsb_pkg::REG_SPRITE_WIDTH:  cfg_in.sprite_width  = csr_data[7:0];
         nsb_pkg::REG_SPRITE_HEIGHT: cfg_in.sprite_height = csr_data[7:0];
         nsb_pkg::REG_CLIP_WIDTH:    cfg_in.clip_width    = csr_data[7:0];
         nsb_pkg::REG_CLIP_HEIGHT:   cfg_in.clip_height   = csr_data[7:0];
         nsb_pkg::REG_TRANSPARENT:   cfg_in.transparent   = csr_data[3:0];
         default:                    hit                  = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x        <= 10'sd0;
         cfg_ff.dest_y        <= 10'sd0;
         cfg_ff.sprite_width  <= 8'd1;
         cfg_ff.sprite_height <= 8'd1;
         cfg_ff.clip_width    <= 8'd255;
         cfg_ff.clip_height   <= 8'd255;
         cfg_ff.transparent   <= 4'd0;
      end else if (csr_valid && hit) begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg     = cfg_ff;
   assign restart = csr_valid && hit;

   assert property (@(posedge clock) disable iff (reset)
      (csr_valid && !hit) |=> $stable(cfg_ff))
      else $error("write to unused index changed configuration");

endmodule

// File: hdl/nsb_cursor.sv
// ----------------------------------------------------------------------------
// nsb_cursor
// Sprite column and row of the next source byte.
// ----------------------------------------------------------------------------
module nsb_cursor (
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  logic             advance,
   input  nsb_pkg::cfg_type cfg,
   output logic [7:0]       col,
   output logic [7:0]       row
);

   logic [7:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic [8:0] next_col;
   logic [8:0] next_row;

   always_comb begin
      next_col = {1'b0, col_ff} + 9'd2;
      next_row = {1'b0, row_ff} + 9'd1;
      col_in   = col_ff;
      row_in   = row_ff;
      if (next_col >= {1'b0, cfg.sprite_width}) begin
         col_in = 8'd0;
         if (next_row >= {1'b0, cfg.sprite_height}) begin
            row_in = 8'd0;
         end else begin
            row_in = next_row[7:0];
         end
      end else begin
         col_in = next_col[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= 8'd0;
         row_ff <= 8'd0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = col_ff;
   assign row = row_ff;

   assert property (@(posedge clock) disable iff (reset)
      col_ff[0] == 1'b0)
      else $error("cursor column is odd");

   assert property (@(posedge clock) disable iff (reset)
      restart |=> (col_ff == 8'd0 && row_ff == 8'd0))
      else $error("cursor not cleared by configuration write");

endmodule

// File: hdl/nsb_pixel.sv
// ----------------------------------------------------------------------------
// nsb_pixel
// Visibility test and buffer address for one sprite pixel.
// ----------------------------------------------------------------------------
module nsb_pixel #(
   parameter int SCREEN_WIDTH  = 220,
   parameter int SCREEN_HEIGHT = 176
) (
   input  nsb_pkg::cfg_type             cfg,
   input  logic [8:0]                   col,
   input  logic [7:0]                   row,
   input  logic [nsb_pkg::COLOR_W-1:0]  color,
   output nsb_pkg::wr_type              wr
);

   localparam int HALF_W = (SCREEN_WIDTH + 1) / 2;

   logic [11:0] sx;
   logic [11:0] sy;
   logic        in_sprite;
   logic        in_clip;
   logic        on_screen;
   logic [20:0] prod;
   logic [20:0] addr_full;

   always_comb begin
      sx = {{2{cfg.dest_x[9]}}, cfg.dest_x} + {3'b000, col};
      sy = {{2{cfg.dest_y[9]}}, cfg.dest_y} + {4'b0000, row};
      in_sprite = (col < {1'b0, cfg.sprite_width}) && (row < cfg.sprite_height);
      in_clip   = (col < {1'b0, cfg.clip_width}) && (row < cfg.clip_height);
      on_screen = !sx[11] && (sx < 12'(SCREEN_WIDTH)) &&
                  !sy[11] && (sy < 12'(SCREEN_HEIGHT));
      prod      = 21'(sy[9:0]) * 21'(HALF_W);
      addr_full = prod + 21'(sx[10:1]);
      wr.en        = in_sprite && in_clip && on_screen && (color != cfg.transparent);
      wr.pix.addr  = addr_full[nsb_pkg::ADDR_W-1:0];
      wr.pix.color = color;
      wr.pix.upper = !sx[0];
   end

endmodule

// File: hdl/nsb_drain.sv
// ----------------------------------------------------------------------------
// nsb_drain
// Result register holding up to two nibble writes of one byte, sent in order.
// ----------------------------------------------------------------------------
module nsb_drain (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  nsb_pkg::wr_type                  w0,
   input  nsb_pkg::wr_type                  w1,
   output logic                             room,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [nsb_pkg::ADDR_W-1:0]       rsp_buffer_address,
   output logic [nsb_pkg::COLOR_W-1:0]      rsp_pixel_color,
   output logic                             rsp_upper_nibble,
   output logic                             rsp_last_of_item
);

   logic             v0_ff, v1_ff;
   nsb_pkg::pix_type d0_ff, d1_ff;
   nsb_pkg::pix_type shown;
   logic             pop;

   assign rsp_valid = v0_ff || v1_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign room      = (!v0_ff && !v1_ff) || ((v0_ff ^ v1_ff) && rsp_ready);
   assign shown     = v0_ff ? d0_ff : d1_ff;

   assign rsp_buffer_address = shown.addr;
   assign rsp_pixel_color    = shown.color;
   assign rsp_upper_nibble   = shown.upper;
   assign rsp_last_of_item   = !(v0_ff && v1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (load) begin
         v0_ff <= w0.en;
         v1_ff <= w1.en;
      end else if (pop) begin
         if (v0_ff) begin
            v0_ff <= 1'b0;
         end else begin
            v1_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         d0_ff <= w0.pix;
         d1_ff <= w1.pix;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      load |-> room)
      else $error("result register overwritten");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_item) |-> v1_ff)
      else $error("non-final write with no write behind it");

endmodule

// File: hdl/nibble_sprite_blitter.sv
// ----------------------------------------------------------------------------
// nibble_sprite_blitter
// Color-keyed 4bpp sprite blit with clipping into a packed frame buffer.
// ----------------------------------------------------------------------------
// first write of a byte leaves the result register, fed by the input register
// throughput: one byte per cycle while rsp_ready is high and bytes cause
//   at most one write each; a two-write byte holds the result register until both are sent
// the single result port sets the rate, one write per cycle while rsp_ready is high
// reset: positions zero, configuration to defaults, pipeline empty
module nibble_sprite_blitter #(
   parameter int SCREEN_WIDTH  = 220,
   parameter int SCREEN_HEIGHT = 176
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_source_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [nsb_pkg::ADDR_W-1:0]       rsp_buffer_address,
   output logic [nsb_pkg::COLOR_W-1:0]      rsp_pixel_color,
   output logic                             rsp_upper_nibble,
   output logic                             rsp_last_of_item,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nsb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nsb_pkg::CSR_DATA_W-1:0]   csr_data
);

   nsb_pkg::cfg_type cfg;
   nsb_pkg::wr_type  w0, w1;
   logic             restart;
   logic             accept;
   logic             room;
   logic             advance;
   logic [7:0]       cur_col, cur_row;

   logic             valid_ff;
   logic [7:0]       byte_ff;
   logic [7:0]       col_ff;
   logic [7:0]       row_ff;

   assign advance   = valid_ff && room;
   assign req_ready = !valid_ff || room;
   assign accept    = req_valid && req_ready;

   nsb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .restart   (restart)
   );

   nsb_cursor u_cursor (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .advance (accept),
      .cfg     (cfg),
      .col     (cur_col),
      .row     (cur_row)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_source_byte;
         col_ff  <= cur_col;
         row_ff  <= cur_row;
      end
   end

   nsb_pixel #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_pixel_left (
      .cfg   (cfg),
      .col   ({1'b0, col_ff}),
      .row   (row_ff),
      .color (4'((byte_ff & nsb_pkg::HIGH_NIBBLE) >> 4)),
      .wr    (w0)
   );

   nsb_pixel #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_pixel_right (
      .cfg   (cfg),
      .col   ({1'b0, col_ff} + 9'd1),
      .row   (row_ff),
      .color (4'(byte_ff & nsb_pkg::LOW_NIBBLE)),
      .wr    (w1)
   );

   nsb_drain u_drain (
      .clock              (clock),
      .reset              (reset),
      .load               (advance),
      .w0                 (w0),
      .w1                 (w1),
      .room               (room),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_buffer_address (rsp_buffer_address),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_upper_nibble   (rsp_upper_nibble),
      .rsp_last_of_item   (rsp_last_of_item)
   );

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !room) |=> (valid_ff && $stable(byte_ff)))
      else $error("stalled byte lost from input register");

   assert property (@(posedge clock) disable iff (reset)
      (advance && (w0.en || w1.en)) |=> rsp_valid)
      else $error("visible pixel produced no write");

endmodule
